@@ hdl/acc8_pkg.sv @@
// ----------------------------------------------------------------------------
// acc8_pkg: shared definitions for the 8-bit accumulator processor
// Word types, command and status codes, the opcode decoder, the ALU and
// the microcode program that drives the instruction sequencer.
// ----------------------------------------------------------------------------
package acc8_pkg;

  // Memory size; must be a power of two so that an address wraps by masking.
  localparam int MEM_WORDS = 256;
  localparam int MEM_AW    = $clog2(MEM_WORDS);

  // Command codes carried by an input word.
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_STEP    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;
  localparam logic [1:0] CMD_NOP     = 2'd3;

  // Status codes reported with every result word.
  localparam logic [1:0] STAT_RUN     = 2'd0;
  localparam logic [1:0] STAT_HALT    = 2'd1;
  localparam logic [1:0] STAT_FAULT   = 2'd2;
  localparam logic [1:0] STAT_IGNORED = 2'd3;

  // Instruction opcodes.
  localparam logic [7:0] OP_LDI  = 8'h00;
  localparam logic [7:0] OP_HLT  = 8'h01;
  localparam logic [7:0] OP_JMP  = 8'h10;
  localparam logic [7:0] OP_JN   = 8'h11;
  localparam logic [7:0] OP_JZ   = 8'h12;
  localparam logic [7:0] OP_ADDI = 8'h20;
  localparam logic [7:0] OP_SUBI = 8'h21;
  localparam logic [7:0] OP_NNDI = 8'h22;
  localparam logic [7:0] OP_LDD  = 8'h40;
  localparam logic [7:0] OP_OUTD = 8'h41;
  localparam logic [7:0] OP_STD  = 8'h48;
  localparam logic [7:0] OP_IND  = 8'h49;
  localparam logic [7:0] OP_ADDD = 8'h60;
  localparam logic [7:0] OP_SUBD = 8'h61;
  localparam logic [7:0] OP_NNDD = 8'h62;
  localparam logic [7:0] OP_LDX  = 8'hC0;
  localparam logic [7:0] OP_OUTX = 8'hC1;
  localparam logic [7:0] OP_STX  = 8'hC8;
  localparam logic [7:0] OP_INX  = 8'hC9;
  localparam logic [7:0] OP_ADDX = 8'hE0;
  localparam logic [7:0] OP_SUBX = 8'hE1;
  localparam logic [7:0] OP_NNDX = 8'hE2;

  // ALU function select, taken from the low two opcode bits.
  localparam logic [1:0] ALU_ADD = 2'd0;
  localparam logic [1:0] ALU_SUB = 2'd1;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] load_address;
    logic [7:0] load_data;
    logic [7:0] input_value;
  } in_word_t;

  typedef struct packed {
    logic              out_valid;
    logic [7:0]        out_value;
    logic [1:0]        status;
    logic [7:0]        program_counter;
    logic signed [7:0] accumulator;
  } out_word_t;

  // Operand addressing mode.
  typedef enum logic [1:0] {
    MODE_IMM,
    MODE_DIR,
    MODE_IND
  } mode_t;

  // What an instruction does once its operand is in hand.
  typedef enum logic [3:0] {
    ACT_LOAD,
    ACT_ALU,
    ACT_OUT,
    ACT_STORE,
    ACT_INPUT,
    ACT_JMP,
    ACT_JN,
    ACT_JZ,
    ACT_HALT,
    ACT_BAD
  } action_t;

  typedef struct packed {
    mode_t   mode;
    action_t action;
  } dec_t;

  // Memory port address source.
  typedef enum logic [1:0] {
    RSEL_NONE,
    RSEL_PC,
    RSEL_MDR
  } ram_sel_t;

  // Sequencer branch kinds.
  typedef enum logic [1:0] {
    BR_NEXT,
    BR_MODE,
    BR_WRITE,
    BR_END
  } branch_t;

  typedef logic [2:0] uaddr_t;

  // Microcode step addresses.
  localparam uaddr_t UA_FETCH = 3'd0;
  localparam uaddr_t UA_OPRD  = 3'd1;
  localparam uaddr_t UA_DISP  = 3'd2;
  localparam uaddr_t UA_EA    = 3'd3;
  localparam uaddr_t UA_PTR   = 3'd4;
  localparam uaddr_t UA_DATA  = 3'd5;
  localparam uaddr_t UA_EXEC  = 3'd6;
  localparam uaddr_t UA_PTRLD = 3'd7;

  // One microcode control word.
  typedef struct packed {
    ram_sel_t ram_sel;
    logic     ram_wr;
    logic     pc_inc;
    logic     op_ld;
    logic     mdr_ld;
    logic     exec;
    branch_t  br;
    uaddr_t   nxt;
  } ctrl_t;

  localparam ctrl_t CTRL_IDLE = '{
    ram_sel: RSEL_NONE, ram_wr: 1'b0, pc_inc: 1'b0, op_ld: 1'b0,
    mdr_ld: 1'b0, exec: 1'b0, br: BR_NEXT, nxt: UA_FETCH
  };

  // Microcode program. Memory read data is registered.
  function automatic ctrl_t ucode(input uaddr_t ua);
    ctrl_t w;
    w = CTRL_IDLE;
    case (ua)
      UA_FETCH: begin
        w.ram_sel = RSEL_PC;
        w.pc_inc  = 1'b1;
        w.nxt     = UA_OPRD;
      end
      UA_OPRD: begin
        w.ram_sel = RSEL_PC;
        w.op_ld   = 1'b1;
        w.nxt     = UA_DISP;
      end
      UA_DISP: begin
        w.mdr_ld  = 1'b1;
        w.br      = BR_MODE;
      end
      UA_EA: begin
        w.ram_sel = RSEL_MDR;
        w.ram_wr  = 1'b1;
        w.br      = BR_WRITE;
      end
      UA_PTR: begin
        w.ram_sel = RSEL_MDR;
        w.nxt     = UA_PTRLD;
      end
      UA_DATA: begin
        w.mdr_ld  = 1'b1;
        w.nxt     = UA_EXEC;
      end
      UA_EXEC: begin
        w.exec    = 1'b1;
        w.br      = BR_END;
      end
      UA_PTRLD: begin
        w.mdr_ld  = 1'b1;
        w.nxt     = UA_EA;
      end
      default: begin
        w = CTRL_IDLE;
      end
    endcase
    return w;
  endfunction

  // Opcode decoder; anything not listed is an illegal instruction.
  function automatic dec_t decode(input logic [7:0] op);
    dec_t d;
    d.mode   = MODE_IMM;
    d.action = ACT_BAD;
    case (op)
      OP_LDI:                   d.action = ACT_LOAD;
      OP_HLT:                   d.action = ACT_HALT;
      OP_JMP:                   d.action = ACT_JMP;
      OP_JN:                    d.action = ACT_JN;
      OP_JZ:                    d.action = ACT_JZ;
      OP_ADDI, OP_SUBI, OP_NNDI: d.action = ACT_ALU;
      OP_LDD:  begin d.mode = MODE_DIR; d.action = ACT_LOAD;  end
      OP_OUTD: begin d.mode = MODE_DIR; d.action = ACT_OUT;   end
      OP_STD:  begin d.mode = MODE_DIR; d.action = ACT_STORE; end
      OP_IND:  begin d.mode = MODE_DIR; d.action = ACT_INPUT; end
      OP_ADDD, OP_SUBD, OP_NNDD: begin
        d.mode   = MODE_DIR;
        d.action = ACT_ALU;
      end
      OP_LDX:  begin d.mode = MODE_IND; d.action = ACT_LOAD;  end
      OP_OUTX: begin d.mode = MODE_IND; d.action = ACT_OUT;   end
      OP_STX:  begin d.mode = MODE_IND; d.action = ACT_STORE; end
      OP_INX:  begin d.mode = MODE_IND; d.action = ACT_INPUT; end
      OP_ADDX, OP_SUBX, OP_NNDX: begin
        d.mode   = MODE_IND;
        d.action = ACT_ALU;
      end
      default: begin
        d.mode   = MODE_IMM;
        d.action = ACT_BAD;
      end
    endcase
    return d;
  endfunction

  // Add, subtract or bitwise NAND, all wrapping at eight bits.
  function automatic logic [7:0] alu(input logic [1:0] kind, input logic [7:0] a,
                                     input logic [7:0] m);
    logic [7:0] r;
    case (kind)
      ALU_ADD: r = a + m;
      ALU_SUB: r = a - m;
      default: r = ~(a & m);
    endcase
    return r;
  endfunction

endpackage

@@ hdl/acc8_if.sv @@
// ----------------------------------------------------------------------------
// acc8_if: word channels of the accumulator processor
// Valid/ready channels for command words in and result words out.
// ----------------------------------------------------------------------------
interface acc8_in_if;
  logic                 valid;
  logic                 ready;
  acc8_pkg::in_word_t   data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface acc8_out_if;
  logic                 valid;
  logic                 ready;
  acc8_pkg::out_word_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/acc8_ram.sv @@
// ----------------------------------------------------------------------------
// acc8_ram: generic single-port RAM
// One read or write per cycle; read data is registered.
// ----------------------------------------------------------------------------
module acc8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read at one address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hdl/acc8_seq.sv @@
// ----------------------------------------------------------------------------
// acc8_seq: microcode sequencer
// Steps through the control program for one instruction and hands the
// current control word to the datapath.
// ----------------------------------------------------------------------------
module acc8_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  acc8_pkg::mode_t   mode,
  input  logic              wr_act,
  output acc8_pkg::ctrl_t   ctl
);

  acc8_pkg::uaddr_t upc;
  logic             running;
  acc8_pkg::ctrl_t  word;

  // Control word lookup; nothing is driven while no instruction runs.
  always_comb begin
    word = acc8_pkg::ucode(upc);
    ctl  = running ? word : acc8_pkg::CTRL_IDLE;
  end

  // Step counter with mode dispatch and the store split.
  always_ff @(posedge clk) begin
    if (rst) begin
      upc     <= acc8_pkg::UA_FETCH;
      running <= 1'b0;
    end else if (start) begin
      upc     <= acc8_pkg::UA_FETCH;
      running <= 1'b1;
    end else if (running) begin
      case (word.br)
        acc8_pkg::BR_NEXT: upc <= word.nxt;
        acc8_pkg::BR_MODE: begin
          case (mode)
            acc8_pkg::MODE_DIR: upc <= acc8_pkg::UA_EA;
            acc8_pkg::MODE_IND: upc <= acc8_pkg::UA_PTR;
            default:            upc <= acc8_pkg::UA_EXEC;
          endcase
        end
        acc8_pkg::BR_WRITE: upc <= wr_act ? acc8_pkg::UA_EXEC : acc8_pkg::UA_DATA;
        default: begin
          upc     <= acc8_pkg::UA_FETCH;
          running <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ hdl/accumulator_cpu_8bit_core.sv @@
// ----------------------------------------------------------------------------
// accumulator_cpu_8bit_core: 8-bit accumulator processor
// Command-driven processor with 256 bytes of memory, run by a microcode
// sequencer over a single-port RAM.
// ----------------------------------------------------------------------------
// Each command word gives exactly one result word. Load, restart, no-op and
// steps ignored while halted go from the idle state straight to the result
// state. A step runs fetch, operand read, dispatch and execute for immediate,
// jump, halt and unknown instructions; direct ones add an address step and a
// data read, double-indirect ones also a pointer read and pointer load, and a
// direct or double-indirect store or input skips the data read. The steps are
// set by the dependent accesses to the single memory port.
// Memory reads as zero after reset: each byte has a valid bit cleared by reset.
// A result word waits in the output register while the next command runs.
module accumulator_cpu_8bit_core (
  input  logic              clk,
  input  logic              rst,
  acc8_in_if.sink           req,
  acc8_out_if.source        rsp
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_POST = 3'b100
  } state_t;

  state_t                 state;
  logic [7:0]             pc;
  logic [7:0]             acc;
  logic                   halt;
  logic                   fault;
  logic [7:0]             op;
  logic [7:0]             mdr;
  logic [7:0]             ival;
  logic                   ovalid;
  logic [7:0]             oval;
  logic [1:0]             status;
  logic                   out_full;
  acc8_pkg::out_word_t    out_word;
  logic [acc8_pkg::MEM_WORDS-1:0] mem_valid;
  logic                   rd_valid;

  logic                   accept;
  logic                   start;
  logic                   take_out;
  acc8_pkg::dec_t         dec;
  acc8_pkg::ctrl_t        ctl;
  logic                   wr_act;
  logic                   ram_we;
  logic [acc8_pkg::MEM_AW-1:0] ram_addr;
  logic [7:0]             ram_wdata;
  logic [7:0]             ram_rdata;
  logic [7:0]             rdata;
  logic                   jump_taken;
  logic [1:0]             idle_status;

  // Handshake and decode.
  assign req.ready   = (state == ST_IDLE);
  assign accept      = req.valid && req.ready;
  assign start       = accept && (req.data.opcode == acc8_pkg::CMD_STEP) && !halt && !fault;
  assign take_out    = !out_full || rsp.ready;
  assign rsp.valid   = out_full;
  assign rsp.data    = out_word;
  assign dec         = acc8_pkg::decode(op);
  assign wr_act      = (dec.action == acc8_pkg::ACT_STORE) ||
                       (dec.action == acc8_pkg::ACT_INPUT);
  assign rdata       = rd_valid ? ram_rdata : 8'd0;
  assign idle_status = fault ? acc8_pkg::STAT_FAULT :
                       (halt ? acc8_pkg::STAT_HALT : acc8_pkg::STAT_RUN);

  // Branch condition for the jump instructions.
  always_comb begin
    case (dec.action)
      acc8_pkg::ACT_JMP: jump_taken = 1'b1;
      acc8_pkg::ACT_JN:  jump_taken = acc[7];
      acc8_pkg::ACT_JZ:  jump_taken = (acc == 8'd0);
      default:           jump_taken = 1'b0;
    endcase
  end

  // Memory port: load commands in the idle state, microcode otherwise.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = pc[acc8_pkg::MEM_AW-1:0];
    ram_wdata = (dec.action == acc8_pkg::ACT_INPUT) ? ival : acc;
    if (accept && (req.data.opcode == acc8_pkg::CMD_LOAD)) begin
      ram_we    = 1'b1;
      ram_addr  = req.data.load_address[acc8_pkg::MEM_AW-1:0];
      ram_wdata = req.data.load_data;
    end else begin
      case (ctl.ram_sel)
        acc8_pkg::RSEL_MDR: begin
          ram_addr = mdr[acc8_pkg::MEM_AW-1:0];
          ram_we   = ctl.ram_wr && wr_act;
        end
        default: ram_addr = pc[acc8_pkg::MEM_AW-1:0];
      endcase
    end
  end

  acc8_ram #(
    .WIDTH (8),
    .DEPTH (acc8_pkg::MEM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  acc8_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (dec.mode),
    .wr_act (wr_act),
    .ctl    (ctl)
  );

  // Per-byte valid bits so that unwritten memory reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      mem_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      rd_valid <= mem_valid[ram_addr];
      if (ram_we) begin
        mem_valid[ram_addr] <= 1'b1;
      end
    end
  end

  // Operand and operand-path registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      ival <= req.data.input_value;
    end
    if (ctl.op_ld) begin
      op <= rdata;
    end
    if (ctl.mdr_ld) begin
      mdr <= rdata;
    end
  end

  // Architectural state, command handling and instruction execution.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      pc     <= 8'd0;
      acc    <= 8'd0;
      halt   <= 1'b0;
      fault  <= 1'b0;
      ovalid <= 1'b0;
      oval   <= 8'd0;
      status <= acc8_pkg::STAT_RUN;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            ovalid <= 1'b0;
            oval   <= 8'd0;
            case (req.data.opcode)
              acc8_pkg::CMD_RESTART: begin
                pc     <= 8'd0;
                acc    <= 8'd0;
                halt   <= 1'b0;
                fault  <= 1'b0;
                status <= acc8_pkg::STAT_RUN;
                state  <= ST_POST;
              end
              acc8_pkg::CMD_STEP: begin
                if (halt || fault) begin
                  status <= acc8_pkg::STAT_IGNORED;
                  state  <= ST_POST;
                end else begin
                  status <= acc8_pkg::STAT_RUN;
                  state  <= ST_RUN;
                end
              end
              default: begin
                status <= idle_status;
                state  <= ST_POST;
              end
            endcase
          end
        end
        ST_RUN: begin
          if (ctl.pc_inc) begin
            pc <= pc + 8'd1;
          end
          if (ctl.exec) begin
            state <= ST_POST;
            // A halt leaves PC just past the opcode.
            if (jump_taken) begin
              pc <= mdr;
            end else if (dec.action != acc8_pkg::ACT_HALT) begin
              pc <= pc + 8'd1;
            end
            case (dec.action)
              acc8_pkg::ACT_LOAD: acc <= mdr;
              acc8_pkg::ACT_ALU:  acc <= acc8_pkg::alu(op[1:0], acc, mdr);
              acc8_pkg::ACT_OUT: begin
                ovalid <= 1'b1;
                oval   <= mdr;
              end
              acc8_pkg::ACT_HALT: begin
                halt   <= 1'b1;
                status <= acc8_pkg::STAT_HALT;
              end
              acc8_pkg::ACT_BAD: begin
                fault  <= 1'b1;
                status <= acc8_pkg::STAT_FAULT;
              end
              default: ;
            endcase
          end
        end
        ST_POST: begin
          if (take_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register holding one result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (state == ST_POST && take_out) begin
      out_full <= 1'b1;
    end else if (rsp.ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_POST && take_out) begin
      out_word.out_valid       <= ovalid;
      out_word.out_value       <= oval;
      out_word.status          <= status;
      out_word.program_counter <= pc;
      out_word.accumulator     <= $signed(acc);
    end
  end

endmodule
